/* rtl/core/assert_macros.svh */
// Assertion helpers used by the protocol checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/owm_pkg.sv */
package owm_pkg;

    localparam int TIMER_WIDTH_DEF = 10;
    localparam int CFG_W           = 10;
    localparam int CFG_IDX_W       = 3;
    localparam int BYTE_W          = 8;
    localparam int BIT_CNT_W       = 3;
    localparam int REST_W          = CFG_W + 2;
    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 16;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_TAIL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TOTAL    = 3'd6;

    localparam logic [CFG_W-1:0] RESET_LOW_DEF     = 10'd480;
    localparam logic [CFG_W-1:0] PRESENCE_WAIT_DEF = 10'd70;
    localparam logic [CFG_W-1:0] PRESENCE_TAIL_DEF = 10'd410;
    localparam logic [CFG_W-1:0] SHORT_LOW_DEF     = 10'd6;
    localparam logic [CFG_W-1:0] LONG_LOW_DEF      = 10'd60;
    localparam logic [CFG_W-1:0] READ_SAMPLE_DEF   = 10'd9;
    localparam logic [CFG_W-1:0] SLOT_TOTAL_DEF    = 10'd70;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_RESET = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_RST_LOW   = 3'd1,
        PH_RST_WAIT  = 3'd2,
        PH_RST_TAIL  = 3'd3,
        PH_SLOT_LOW  = 3'd4,
        PH_SLOT_WAIT = 3'd5,
        PH_SLOT_REST = 3'd6
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_us;
        logic [CFG_W-1:0] presence_wait_us;
        logic [CFG_W-1:0] presence_tail_us;
        logic [CFG_W-1:0] short_low_us;
        logic [CFG_W-1:0] long_low_us;
        logic [CFG_W-1:0] read_sample_us;
        logic [CFG_W-1:0] slot_total_us;
    } cfg_t;

    typedef struct packed {
        logic              rejected;
        logic [BYTE_W-1:0] read_data;
        logic              present;
        logic              done_res;
        logic              busy_res;
        logic              drive_low;
    } result_t;

    // A zero duration still lasts one tick.
    function automatic logic [CFG_W-1:0] at_least_one(input logic [CFG_W-1:0] v);
        return (v == '0) ? CFG_W'(1) : v;
    endfunction

endpackage

/* rtl/core/owm_cfg_regs.sv */
module owm_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [owm_pkg::CFG_W-1:0]     cfg_data,
    output owm_pkg::cfg_t                 cfg
);
    import owm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RESET_LOW:     cfg_next.reset_low_us     = cfg_data;
                CFG_PRESENCE_WAIT: cfg_next.presence_wait_us = cfg_data;
                CFG_PRESENCE_TAIL: cfg_next.presence_tail_us = cfg_data;
                CFG_SHORT_LOW:     cfg_next.short_low_us     = cfg_data;
                CFG_LONG_LOW:      cfg_next.long_low_us      = cfg_data;
                CFG_READ_SAMPLE:   cfg_next.read_sample_us   = cfg_data;
                CFG_SLOT_TOTAL:    cfg_next.slot_total_us    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_us     <= RESET_LOW_DEF;
            cfg_reg.presence_wait_us <= PRESENCE_WAIT_DEF;
            cfg_reg.presence_tail_us <= PRESENCE_TAIL_DEF;
            cfg_reg.short_low_us     <= SHORT_LOW_DEF;
            cfg_reg.long_low_us      <= LONG_LOW_DEF;
            cfg_reg.read_sample_us   <= READ_SAMPLE_DEF;
            cfg_reg.slot_total_us    <= SLOT_TOTAL_DEF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/owm_engine.sv */
module owm_engine
#(
    parameter int TIMER_WIDTH = owm_pkg::TIMER_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  owm_pkg::action_t           action,
    input  logic [owm_pkg::BYTE_W-1:0] data_byte,
    input  logic                       line_level,
    input  owm_pkg::cfg_t              cfg,
    output owm_pkg::result_t           result
);
    import owm_pkg::*;

    localparam int CW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

    phase_t                 phase_reg,  phase_next;
    action_t                op_reg,     op_next;
    logic [TIMER_WIDTH-1:0] cnt_reg,    cnt_next;
    logic [BYTE_W-1:0]      shift_reg,  shift_next;
    logic [BIT_CNT_W-1:0]   bits_reg,   bits_next;
    logic                   pres_reg,   pres_next;
    logic                   drive_reg,  drive_next;

    logic [TIMER_WIDTH-1:0] cnt_inc;
    logic [CFG_W-1:0]       low_len;
    logic [CFG_W-1:0]       rest_a;
    logic [CFG_W-1:0]       rest_b;
    logic [REST_W-1:0]      rest_diff;
    logic                   rest_zero;
    logic [CFG_W-1:0]       thr;
    logic                   reached;
    logic                   end_slot;
    logic                   fin;
    logic                   rej;

    assign cnt_inc = cnt_reg + TIMER_WIDTH'(1);

    // Low pulse: long only for a write of a zero bit
    assign low_len = (op_reg == ACT_WRITE && !shift_reg[0]) ? at_least_one(cfg.long_low_us)
                                                            : at_least_one(cfg.short_low_us);

    // Slot remainder after low pulse (and sample wait for reads), floored at zero
    always_comb
    begin
        if (op_reg == ACT_READ)
        begin
            rest_a = at_least_one(cfg.short_low_us);
            rest_b = at_least_one(cfg.read_sample_us);
        end
        else
        begin
            rest_a = low_len;
            rest_b = '0;
        end
    end

    assign rest_diff = REST_W'(cfg.slot_total_us) - REST_W'(rest_a) - REST_W'(rest_b);
    assign rest_zero = rest_diff[REST_W-1] || (rest_diff == '0);

    always_comb
    begin
        case (phase_reg)
            PH_RST_LOW:   thr = at_least_one(cfg.reset_low_us);
            PH_RST_WAIT:  thr = at_least_one(cfg.presence_wait_us);
            PH_RST_TAIL:  thr = at_least_one(cfg.presence_tail_us);
            PH_SLOT_LOW:  thr = low_len;
            PH_SLOT_WAIT: thr = at_least_one(cfg.read_sample_us);
            PH_SLOT_REST: thr = rest_zero ? '0 : rest_diff[CFG_W-1:0];
            default:      thr = '0;
        endcase
    end

    assign reached = CW'(cnt_inc) >= CW'(thr);

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        pres_next  = pres_reg;
        drive_next = drive_reg;
        end_slot   = 1'b0;
        fin        = 1'b0;
        rej        = 1'b0;
        if (fire)
        begin
            if (action != ACT_TICK)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    op_next    = action;
                    cnt_next   = '0;
                    bits_next  = '0;
                    drive_next = 1'b1;
                    if (action == ACT_RESET)
                    begin
                        phase_next = PH_RST_LOW;
                    end
                    else
                    begin
                        shift_next = (action == ACT_WRITE) ? data_byte : '0;
                        phase_next = PH_SLOT_LOW;
                    end
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                cnt_next = cnt_inc;
                case (phase_reg)
                    PH_RST_LOW:
                    begin
                        if (reached)
                        begin
                            cnt_next   = '0;
                            drive_next = 1'b0;
                            phase_next = PH_RST_WAIT;
                        end
                    end
                    PH_RST_WAIT:
                    begin
                        if (reached)
                        begin
                            pres_next  = ~line_level;
                            cnt_next   = '0;
                            phase_next = PH_RST_TAIL;
                        end
                    end
                    PH_RST_TAIL:
                    begin
                        if (reached)
                        begin
                            cnt_next   = '0;
                            phase_next = PH_IDLE;
                            fin        = 1'b1;
                        end
                    end
                    PH_SLOT_LOW:
                    begin
                        if (reached)
                        begin
                            cnt_next   = '0;
                            drive_next = 1'b0;
                            if (op_reg == ACT_READ)
                                phase_next = PH_SLOT_WAIT;
                            else if (rest_zero)
                                end_slot = 1'b1;
                            else
                                phase_next = PH_SLOT_REST;
                        end
                    end
                    PH_SLOT_WAIT:
                    begin
                        if (reached)
                        begin
                            shift_next = {line_level, shift_reg[BYTE_W-1:1]};
                            cnt_next   = '0;
                            if (rest_zero)
                                end_slot = 1'b1;
                            else
                                phase_next = PH_SLOT_REST;
                        end
                    end
                    PH_SLOT_REST:
                    begin
                        if (reached)
                            end_slot = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        drive_next = 1'b0;
                        cnt_next   = '0;
                    end
                endcase

                if (end_slot)
                begin
                    if (op_reg == ACT_WRITE)
                        shift_next = shift_reg >> 1;
                    cnt_next = '0;
                    if (bits_reg == LAST_BIT)
                    begin
                        phase_next = PH_IDLE;
                        drive_next = 1'b0;
                        fin        = 1'b1;
                    end
                    else
                    begin
                        bits_next  = bits_reg + BIT_CNT_W'(1);
                        drive_next = 1'b1;
                        phase_next = PH_SLOT_LOW;
                    end
                end
            end
        end
    end

    // Result of this item
    always_comb
    begin
        result.drive_low = drive_next;
        result.busy_res  = (phase_next != PH_IDLE);
        result.done_res  = fin;
        result.present   = pres_next;
        result.read_data = (fin && op_reg == ACT_READ) ? shift_next : '0;
        result.rejected  = rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            op_reg    <= ACT_TICK;
            cnt_reg   <= '0;
            shift_reg <= '0;
            bits_reg  <= '0;
            pres_reg  <= 1'b0;
            drive_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            pres_reg  <= pres_next;
            drive_reg <= drive_next;
        end
    end

endmodule

/* rtl/core/one_wire_bus_master.sv */
// Channel  Direction  Handshake                 Content
// s_*      in         s_tvalid / s_tready       tick or command item
// m_*      out        m_tvalid / m_tready       one result item per input item
// cfg_*    in         cfg_valid / cfg_ready     timing register write
//
// Throughput is one item per clock while m_tready does not stall the result; the
// state update for an item is a single counter compare and phase step in owm_engine.
// An item passes through the input register, then the result register.
// A stalled m_tready holds the result; the input register still takes one more
// item, then s_tready drops until the result is taken.
// Reset puts the sequencer in idle and loads the default timings; no clearing pass.
module one_wire_bus_master
#(
    parameter int TIMER_WIDTH = owm_pkg::TIMER_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [owm_pkg::S_TDATA_W-1:0] s_tdata,   // data_byte[7:0], line_level[8], zero
    input  logic [1:0]                    s_tuser,   // action[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // drive_low[0], busy_res[1], done_res[2], present[3], read_data[11:4],
    // rejected[12], zero
    output logic [owm_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [owm_pkg::CFG_W-1:0]     cfg_data
);
    import owm_pkg::*;

    logic              in_valid_reg,  in_valid_next;
    action_t           in_action_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_level_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg;

    cfg_t    cfg;
    result_t result;
    logic    fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_comb
    begin
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (fire)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    owm_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owm_engine #(.TIMER_WIDTH(TIMER_WIDTH)) u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .action     (in_action_reg),
        .data_byte  (in_data_reg),
        .line_level (in_level_reg),
        .cfg        (cfg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_action_reg <= action_t'(s_tuser);
            in_data_reg   <= s_tdata[BYTE_W-1:0];
            in_level_reg  <= s_tdata[BYTE_W];
        end
        if (fire)
            out_res_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_res_reg);

endmodule

/* rtl/core/owm_checker.sv */
module owm_protocol_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [owm_pkg::M_TDATA_W-1:0] m_tdata
);
    `include "assert_macros.svh"

    // Result held while the sink stalls
    `OWM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata), "result dropped while stalled")

    // Finishing item leaves the bus master idle
    `OWM_ASSERT_NOW(a_done_idle, m_tvalid && m_tdata[2], !m_tdata[1], "done while still busy")

    // A rejected command can only hit a running operation
    `OWM_ASSERT_NOW(a_rej_busy, m_tvalid && m_tdata[12], m_tdata[1], "reject while idle")

    // Line is pulled low only during an operation; read byte only on done
    `OWM_ASSERT_NOW(a_drive_busy, m_tvalid && m_tdata[0], m_tdata[1], "line driven while idle")
    `OWM_ASSERT_NOW(a_rdata_done, m_tvalid && (m_tdata[11:4] != 8'd0), m_tdata[2],
                    "read byte without done")

endmodule

bind one_wire_bus_master owm_protocol_checker u_owm_checker (.*);
